FILE: src/sfdp_pkg.sv
// Shared types and constants for the facilitation/depression plasticity block.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sfdp_pkg;

  localparam int FRAC      = 12;
  localparam int SYN_W     = 8;
  localparam int WEIGHT_W  = 20;
  localparam int FACTOR_W  = 16;
  localparam int STEP_W    = 32;
  localparam int DELTA_W   = 16;
  localparam int Q12_W     = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [Q12_W-1:0]    ONE        = Q12_W'(1 << FRAC);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_FD  = 2'd1;
  localparam logic [1:0] MODE_DD  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_FAC_INC   = 3'd1,
    CFG_DEP1_FAC  = 3'd2,
    CFG_DEP2_FAC  = 3'd3,
    CFG_FAC_DECAY = 3'd4,
    CFG_DEP1_DEC  = 3'd5,
    CFG_DEP2_DEC  = 3'd6,
    CFG_WINDOW    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_POW_INIT,
    ST_POW_BIT,
    ST_POW_ACC,
    ST_POW_SQ,
    ST_UPD1,
    ST_UPD2,
    ST_WGT1,
    ST_WGT2,
    ST_WRITE,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC,
    OP_SQ,
    OP_FAC,
    OP_DSCALE,
    OP_DGAP,
    OP_W1,
    OP_W2
  } mul_op_t;

  typedef struct packed {
    logic       in_ready;
    logic       read;
    logic       latch;
    mul_op_t    op;
    logic       pow_init;
    logic       part;
    logic [3:0] bit_idx;
    logic       finish;
    logic       write;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_range;
    logic is_load;
    logic qualify;
    logic valid_bit;
    logic mode2;
    logic delta_bit;
    logic out_free;
  } dp_status_t;

  function automatic logic [Q12_W-1:0] clamp_one(input logic [Q12_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  function automatic logic [FACTOR_W-1:0] sat_factor(input logic signed [35:0] v);
    if (v < 0) return '0;
    if (v > 36'sd65535) return FACTOR_MAX;
    return v[FACTOR_W-1:0];
  endfunction

endpackage

FILE: src/sfdp_if.sv
// Channel interfaces: request items, result items and configuration writes.
// Depends on sfdp_pkg for field widths.
`timescale 1ns / 1ps

interface sfdp_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sfdp_pkg::SYN_W-1:0]    synapse;
  logic [sfdp_pkg::WEIGHT_W-1:0] weight_in;
  logic [sfdp_pkg::STEP_W-1:0]   current_step;
  logic [sfdp_pkg::STEP_W-1:0]   spike_step;
  logic                         has_fired;
  modport source (output valid, kind, synapse, weight_in, current_step, spike_step,
                  has_fired, input ready);
  modport sink (input valid, kind, synapse, weight_in, current_step, spike_step,
                has_fired, output ready);
endinterface

interface sfdp_res_if;
  logic                         valid;
  logic                         ready;
  logic [sfdp_pkg::SYN_W-1:0]    synapse_out;
  logic [sfdp_pkg::WEIGHT_W-1:0] weight_out;
  logic [sfdp_pkg::FACTOR_W-1:0] factor_a_out;
  logic [sfdp_pkg::FACTOR_W-1:0] factor_b_out;
  logic                         updated;
  modport source (output valid, synapse_out, weight_out, factor_a_out, factor_b_out,
                  updated, input ready);
  modport sink (input valid, synapse_out, weight_out, factor_a_out, factor_b_out,
                updated, output ready);
endinterface

interface sfdp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfdp_pkg::CFG_IDX_W-1:0] index;
  logic [sfdp_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/sfdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sfdp_ctrl.sv
// Sequencer for one item: table read, power loops, factor updates, weight, write-back.
// Depends on sfdp_pkg for the state, command and status types.
`timescale 1ns / 1ps

module sfdp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  sfdp_pkg::dp_status_t status,
  output sfdp_pkg::ctrl_cmd_t  cmd
);
  import sfdp_pkg::*;

  ctrl_state_t state, state_next;
  logic        wait_q, wait_next;
  logic        part, part_next;
  logic [3:0]  bit_idx, bit_next;
  logic        fac_case;

  // part a in mode 1 takes the facilitation rule, everything else depresses
  assign fac_case = !part && !status.mode2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wait_q  <= 1'b0;
      part    <= 1'b0;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      wait_q  <= wait_next;
      part    <= part_next;
      bit_idx <= bit_next;
    end
  end

  always_comb begin
    state_next = state;
    wait_next  = 1'b0;
    part_next  = part;
    bit_next   = bit_idx;
    case (state)
      ST_IDLE: begin
        if (status.in_fire) state_next = ST_READ;
      end
      ST_READ: state_next = ST_DECIDE;
      ST_DECIDE: begin
        part_next = 1'b0;
        if (!status.in_range) state_next = ST_OUT;
        else if (!status.is_load && status.qualify && status.valid_bit)
          state_next = ST_POW_INIT;
        else state_next = ST_WGT1;
      end
      ST_POW_INIT: begin
        bit_next   = '0;
        state_next = ST_POW_BIT;
      end
      ST_POW_BIT: state_next = status.delta_bit ? ST_POW_ACC : ST_POW_SQ;
      ST_POW_ACC: begin
        wait_next = !wait_q;
        if (wait_q) state_next = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        wait_next = !wait_q;
        if (wait_q) begin
          if (bit_idx == 4'd15) begin
            state_next = ST_UPD1;
          end else begin
            bit_next   = bit_idx + 4'd1;
            state_next = ST_POW_BIT;
          end
        end
      end
      ST_UPD1: begin
        wait_next = !wait_q;
        if (wait_q) begin
          if (fac_case) begin
            part_next  = 1'b1;
            state_next = ST_POW_INIT;
          end else begin
            state_next = ST_UPD2;
          end
        end
      end
      ST_UPD2: begin
        wait_next = !wait_q;
        if (wait_q) begin
          if (!part) begin
            part_next  = 1'b1;
            state_next = ST_POW_INIT;
          end else begin
            state_next = ST_WGT1;
          end
        end
      end
      ST_WGT1: begin
        wait_next = !wait_q;
        if (wait_q) state_next = ST_WGT2;
      end
      ST_WGT2: begin
        wait_next = !wait_q;
        if (wait_q) state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.part     = part;
    cmd.bit_idx  = bit_idx;
    case (state)
      ST_IDLE:     cmd.in_ready = 1'b1;
      ST_READ:     cmd.read     = 1'b1;
      ST_DECIDE:   cmd.latch    = 1'b1;
      ST_POW_INIT: cmd.pow_init = 1'b1;
      ST_POW_ACC:  if (!wait_q) cmd.op = OP_ACC;
      ST_POW_SQ:   if (!wait_q) cmd.op = OP_SQ;
      ST_UPD1:     if (!wait_q) cmd.op = fac_case ? OP_FAC : OP_DSCALE;
      ST_UPD2: begin
        if (!wait_q) cmd.op = OP_DGAP;
        cmd.finish = wait_q && part;
      end
      ST_WGT1:     if (!wait_q) cmd.op = OP_W1;
      ST_WGT2:     if (!wait_q) cmd.op = OP_W2;
      ST_WRITE:    cmd.write = 1'b1;
      ST_OUT:      cmd.emit  = status.out_free;
      default: ;
    endcase
  end

  a_fire_to_read: assert property (@(posedge clk) disable iff (rst)
    status.in_fire |=> state == ST_READ)
    else $error("accepted item did not start a table read");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !status.out_free) |=> state == ST_OUT)
    else $error("result left before the output register was free");

  a_wait_one: assert property (@(posedge clk) disable iff (rst)
    wait_q |=> !wait_q)
    else $error("multiply wait lasted more than one cycle");

endmodule

FILE: src/sfdp_datapath.sv
// Datapath: config registers, synapse table, valid bits, shared multiplier, result register.
// Depends on sfdp_pkg, the channel interfaces and sfdp_ram.
`timescale 1ns / 1ps

module sfdp_datapath #(
  parameter int NUM_SYNAPSES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  sfdp_req_if.sink             request,
  sfdp_res_if.source           result,
  sfdp_cfg_if.sink             cfg,
  input  sfdp_pkg::ctrl_cmd_t  cmd,
  output sfdp_pkg::dp_status_t status
);
  import sfdp_pkg::*;

  localparam int DEPTH  = (NUM_SYNAPSES > 256) ? 256 : NUM_SYNAPSES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = STEP_W + 2 * FACTOR_W + WEIGHT_W;
  localparam int PROD_W = 44;

  // configuration
  logic [1:0]          mode;
  logic [FACTOR_W-1:0] fac_inc;
  logic [Q12_W-1:0]    dep1_fac, dep2_fac, fac_dec, dep1_dec, dep2_dec;
  logic [15:0]         window;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_FD;
      fac_inc  <= 16'd819;
      dep1_fac <= ONE;
      dep2_fac <= ONE;
      fac_dec  <= 13'd4095;
      dep1_dec <= 13'd4095;
      dep2_dec <= 13'd4095;
      window   <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_MODE:      mode     <= cfg.data[1:0];
        CFG_FAC_INC:   fac_inc  <= cfg.data;
        CFG_DEP1_FAC:  dep1_fac <= cfg.data[Q12_W-1:0];
        CFG_DEP2_FAC:  dep2_fac <= cfg.data[Q12_W-1:0];
        CFG_FAC_DECAY: fac_dec  <= cfg.data[Q12_W-1:0];
        CFG_DEP1_DEC:  dep1_dec <= cfg.data[Q12_W-1:0];
        CFG_DEP2_DEC:  dep2_dec <= cfg.data[Q12_W-1:0];
        CFG_WINDOW:    window   <= cfg.data;
        default: ;
      endcase
    end
  end

  // captured request
  logic                in_fire;
  logic                cap_kind, cap_fired;
  logic [SYN_W-1:0]    cap_syn;
  logic [WEIGHT_W-1:0] cap_win;
  logic [STEP_W-1:0]   cap_cur, cap_spk;

  assign request.ready = cmd.in_ready;
  assign in_fire       = request.valid && cmd.in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cap_kind  <= request.kind;
      cap_syn   <= request.synapse;
      cap_win   <= request.weight_in;
      cap_cur   <= request.current_step;
      cap_spk   <= request.spike_step;
      cap_fired <= request.has_fired;
    end
  end

  // table
  logic [AW-1:0]       addr;
  logic [ROW_W-1:0]    rd_row;
  logic                in_range;
  logic [DEPTH-1:0]    vbits;

  logic [WEIGHT_W-1:0] base_w;
  logic [FACTOR_W-1:0] fa, fb;
  logic [STEP_W-1:0]   last;

  assign addr     = AW'(cap_syn);
  assign in_range = 32'(cap_syn) < DEPTH;

  sfdp_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (cmd.write && in_range),
    .waddr (addr),
    .wdata ({last, fb, fa, base_w}),
    .re    (cmd.read),
    .raddr (addr),
    .rdata (rd_row)
  );

  logic [WEIGHT_W-1:0] mem_base;
  logic [FACTOR_W-1:0] mem_fa, mem_fb;
  logic [STEP_W-1:0]   mem_last;
  assign {mem_last, mem_fb, mem_fa, mem_base} = rd_row;

  // spike qualification and elapsed steps
  logic              qualify;
  logic [STEP_W:0]   win_end;
  logic [STEP_W-1:0] diff;
  logic [DELTA_W-1:0] delta_calc;

  assign win_end = {1'b0, cap_spk} + {17'd0, window};
  assign qualify = (mode == MODE_FD || mode == MODE_DD) && cap_fired &&
                   (cap_cur >= cap_spk) && ({1'b0, cap_cur} < win_end);
  assign diff    = cap_cur - mem_last;
  always_comb begin
    if (cap_cur <= mem_last)       delta_calc = '0;
    else if (diff[31:16] != 16'd0) delta_calc = '1;
    else                           delta_calc = diff[DELTA_W-1:0];
  end

  // working registers
  logic [DELTA_W-1:0]  delta;
  logic [Q12_W-1:0]    acc, pbase;
  logic [FACTOR_W-1:0] scaled;
  logic [23:0]         w1;
  logic [WEIGHT_W-1:0] wout;
  logic                upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (cmd.latch && in_range && !cap_kind) begin
      vbits[addr] <= 1'b0;
    end else if (cmd.latch && in_range && qualify && !vbits[addr]) begin
      vbits[addr] <= 1'b1;
    end
  end

  // shared multiplier: issue registers the product, the next cycle rounds and writes back
  mul_op_t                   op_q;
  logic                      part_q;
  logic signed [25:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [FACTOR_W-1:0]       tgt;
  logic [Q12_W-1:0]          dep_mult;
  logic [Q12_W-1:0]          pow_decay;

  assign tgt       = cmd.part ? fb : fa;
  assign dep_mult  = clamp_one((cmd.part && status.mode2) ? dep2_fac : dep1_fac);
  assign pow_decay = clamp_one(cmd.part ? (status.mode2 ? dep2_dec : dep1_dec)
                                        : (status.mode2 ? dep1_dec : fac_dec));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_ACC: begin
        mul_a = 26'(acc);
        mul_b = 18'(pbase);
      end
      OP_SQ: begin
        mul_a = 26'(pbase);
        mul_b = 18'(pbase);
      end
      OP_FAC: begin
        mul_a = 26'($signed(18'(fa)) + $signed(18'(fac_inc)) - $signed(18'(ONE)));
        mul_b = 18'(acc);
      end
      OP_DSCALE: begin
        mul_a = 26'(tgt);
        mul_b = 18'(dep_mult);
      end
      OP_DGAP: begin
        mul_a = 26'($signed(18'(ONE)) - $signed(18'(scaled)));
        mul_b = 18'(acc);
      end
      OP_W1: begin
        mul_a = 26'(base_w);
        mul_b = 18'(fa);
      end
      OP_W2: begin
        mul_a = 26'(w1);
        mul_b = 18'(fb);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NONE;
    end else begin
      op_q <= cmd.op;
    end
    part_q <= cmd.part;
    prod   <= mul_a * mul_b;
  end

  // round the magnitude half up, keep the sign
  logic                     neg;
  logic [PROD_W-1:0]        mag, rmag;
  logic signed [35:0]       rres;
  logic [FACTOR_W-1:0]      fac_new, dep_new;
  logic [31:0]              w2_full;

  assign neg     = prod[PROD_W-1];
  assign mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
  assign rmag    = (mag + PROD_W'(1 << (FRAC - 1))) >> FRAC;
  assign rres    = neg ? -$signed(36'(rmag)) : $signed(36'(rmag));
  assign fac_new = sat_factor($signed(36'(ONE)) + rres);
  assign dep_new = sat_factor($signed(36'(ONE)) - rres);
  assign w2_full = rmag[31:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      delta <= delta_calc;
      upd   <= 1'b0;
      if (!cap_kind) begin
        base_w <= cap_win;
        fa     <= FACTOR_W'(ONE);
        fb     <= FACTOR_W'(ONE);
        last   <= mem_last;
      end else begin
        base_w <= mem_base;
        fa     <= mem_fa;
        fb     <= mem_fb;
        last   <= (qualify && !vbits[addr]) ? cap_spk : mem_last;
      end
    end
    if (cmd.pow_init) begin
      acc   <= ONE;
      pbase <= pow_decay;
    end
    if (cmd.finish) begin
      last <= cap_cur;
      upd  <= 1'b1;
    end
    case (op_q)
      OP_ACC:    acc    <= rmag[Q12_W-1:0];
      OP_SQ:     pbase  <= rmag[Q12_W-1:0];
      OP_FAC:    if (part_q) fb <= fac_new; else fa <= fac_new;
      OP_DSCALE: scaled <= rmag[FACTOR_W-1:0];
      OP_DGAP:   if (part_q) fb <= dep_new; else fa <= dep_new;
      OP_W1:     w1     <= rmag[23:0];
      OP_W2:     wout   <= (w2_full > 32'(WEIGHT_MAX)) ? WEIGHT_MAX : w2_full[WEIGHT_W-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.synapse_out  <= cap_syn;
      result.weight_out   <= in_range ? wout : '0;
      result.factor_a_out <= in_range ? fa : '0;
      result.factor_b_out <= in_range ? fb : '0;
      result.updated      <= in_range && upd;
    end
  end

  always_comb begin
    status           = '0;
    status.in_fire   = in_fire;
    status.in_range  = in_range;
    status.is_load   = !cap_kind;
    status.qualify   = qualify;
    status.valid_bit = vbits[addr];
    status.mode2     = (mode == MODE_DD);
    status.delta_bit = delta[cmd.bit_idx];
    status.out_free  = !result.valid || result.ready;
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> in_range)
    else $error("table write for an index beyond the table");

  a_pow_bounded: assert property (@(posedge clk) disable iff (rst)
    (op_q == OP_ACC || op_q == OP_SQ) |=> (acc <= ONE && pbase <= ONE))
    else $error("decay power left the range 0..1");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result.valid || result.ready))
    else $error("result overwritten before transfer");

endmodule

FILE: src/synapse_fac_dep_plasticity.sv
// Short-term plasticity unit: synapse table with facilitation and depression factors.
// Depends on sfdp_pkg, sfdp_if, sfdp_ctrl and sfdp_datapath.
`timescale 1ns / 1ps

// One request at a time. Each request takes a table read and a decision step; an
// in-range request then takes the weight product (two multiplies), a write-back and
// the result transfer, while an out-of-range request goes straight to the transfer.
// An updating spike adds two decay powers, formed by square-and-multiply over the
// 16-bit elapsed step count on the one shared multiplier, and one or two multiplies
// per factor rule. The next request is taken while the finished result still waits
// in the output register. The table has no clearing pass; only the per-synapse
// update marks reset.
module synapse_fac_dep_plasticity #(
  parameter int NUM_SYNAPSES = 256
) (
  input logic        clk,
  input logic        rst,
  sfdp_req_if.sink   request,
  sfdp_res_if.source result,
  sfdp_cfg_if.sink   cfg
);
  import sfdp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfdp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sfdp_datapath #(.NUM_SYNAPSES(NUM_SYNAPSES)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

FILE: verif/sfdp_tb_if.sv
// Note on this file: the interfaces come with the RTL in src/sfdp_if.sv.
// The testbench reuses those interfaces; this file only holds the result type and the scoreboard class.
// Depends on sfdp_pkg.
`timescale 1ns / 1ps

package sfdp_tb_pkg;
  import sfdp_pkg::*;

  typedef struct {
    logic [7:0]  syn;
    logic [19:0] weight;
    logic [15:0] fa;
    logic [15:0] fb;
    logic        upd;
  } plast_result_t;

  class plasticity_scoreboard;
    logic [1:0]  mode;
    logic [15:0] fac_inc;
    logic [12:0] dep1_fac, dep2_fac, fac_dec, dep1_dec, dep2_dec;
    logic [15:0] window;
    logic [19:0] base_w [256];
    logic [15:0] fac_a [256];
    logic [15:0] fac_b [256];
    logic [31:0] last_step [256];
    bit          marked [256];
    plast_result_t pending[$];
    int          errors;

    function new();
      mode = MODE_FD; fac_inc = 819; dep1_fac = 4096; dep2_fac = 4096;
      fac_dec = 4095; dep1_dec = 4095; dep2_dec = 4095; window = 1;
      foreach (marked[i]) marked[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] d);
      case (idx)
        CFG_MODE:      mode = d[1:0];
        CFG_FAC_INC:   fac_inc = d;
        CFG_DEP1_FAC:  dep1_fac = d[12:0];
        CFG_DEP2_FAC:  dep2_fac = d[12:0];
        CFG_FAC_DECAY: fac_dec = d[12:0];
        CFG_DEP1_DEC:  dep1_dec = d[12:0];
        CFG_DEP2_DEC:  dep2_dec = d[12:0];
        CFG_WINDOW:    window = d;
        default: ;
      endcase
    endfunction

    function longint rnd(longint v);
      if (v < 0) return -((-v + 2048) >>> 12);
      return (v + 2048) >>> 12;
    endfunction

    function longint lim_one(logic [12:0] v);
      return (v > 4096) ? 4096 : v;
    endfunction

    function logic [15:0] clip16(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
    endfunction

    function longint decay_pow(logic [12:0] dec, logic [15:0] n);
      longint b, acc;
      b = lim_one(dec);
      acc = 4096;
      for (int i = 0; i < 16; i++) begin
        if (n[i]) acc = rnd(acc * b);
        b = rnd(b * b);
      end
      return acc;
    endfunction

    function logic [15:0] depressed(logic [15:0] d, logic [12:0] m, longint p);
      longint gap;
      gap = 4096 - rnd(longint'(d) * lim_one(m));
      return clip16(4096 - rnd(gap * p));
    endfunction

    function void note_request(logic kind, logic [7:0] s, logic [19:0] w,
                               logic [31:0] cur, logic [31:0] spk, logic fired);
      plast_result_t r;
      longint dl, wt, boost;
      r.syn = s; r.upd = 0;
      if (kind == 0) begin
        base_w[s] = w; fac_a[s] = 4096; fac_b[s] = 4096; marked[s] = 0;
      end else if ((mode == MODE_FD || mode == MODE_DD) && fired &&
                   longint'(cur) >= longint'(spk) &&
                   longint'(cur) < longint'(spk) + longint'(window)) begin
        if (!marked[s]) begin
          last_step[s] = spk; marked[s] = 1;
        end else begin
          dl = (cur > last_step[s]) ? longint'(cur - last_step[s]) : 0;
          if (dl > 65535) dl = 65535;
          if (mode == MODE_FD) begin
            boost = longint'(fac_a[s]) + fac_inc - 4096;
            fac_a[s] = clip16(4096 + rnd(boost * decay_pow(fac_dec, dl[15:0])));
            fac_b[s] = depressed(fac_b[s], dep1_fac, decay_pow(dep1_dec, dl[15:0]));
          end else begin
            fac_a[s] = depressed(fac_a[s], dep1_fac, decay_pow(dep1_dec, dl[15:0]));
            fac_b[s] = depressed(fac_b[s], dep2_fac, decay_pow(dep2_dec, dl[15:0]));
          end
          last_step[s] = cur;
          r.upd = 1;
        end
      end
      wt = rnd(rnd(longint'(base_w[s]) * fac_a[s]) * fac_b[s]);
      r.weight = (wt > 1048575) ? 20'hFFFFF : wt[19:0];
      r.fa = fac_a[s]; r.fb = fac_b[s];
      pending.push_back(r);
    endfunction

    function void check_result(plast_result_t got);
      plast_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result for synapse %0d", got.syn);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.syn !== e.syn) begin
        $error("synapse_out exp %0d got %0d", e.syn, got.syn); errors++;
      end
      if (got.weight !== e.weight) begin
        $error("weight_out exp %0d got %0d", e.weight, got.weight); errors++;
      end
      if (got.fa !== e.fa) begin
        $error("factor_a_out exp %0d got %0d", e.fa, got.fa); errors++;
      end
      if (got.fb !== e.fb) begin
        $error("factor_b_out exp %0d got %0d", e.fb, got.fb); errors++;
      end
      if (got.upd !== e.upd) begin
        $error("updated exp %0d got %0d", e.upd, got.upd); errors++;
      end
    endfunction
  endclass
endpackage

FILE: verif/testbench.sv
// Testbench for synapse_fac_dep_plasticity: random and directed load/spike traffic,
// checked against the plasticity scoreboard. Depends on sfdp_pkg, sfdp_if, sfdp_tb_pkg.
`timescale 1ns / 1ps

module testbench;
  import sfdp_pkg::*;
  import sfdp_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 0;
  bit   loaded [256];
  logic [31:0] clock_step [256];
  plasticity_scoreboard board;

  sfdp_req_if request ();
  sfdp_res_if result ();
  sfdp_cfg_if cfg ();

  synapse_fac_dep_plasticity i_dut (
    .clk(clk), .rst(rst), .request(request), .result(result), .cfg(cfg)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("[synapse_fac_dep_plasticity] ERROR");
    $finish;
  end

  initial begin
    request.valid = 0; request.kind = 0; request.synapse = 0; request.weight_in = 0;
    request.current_step = 0; request.spike_step = 0; request.has_fired = 0;
    result.ready = 0;
    cfg.valid = 0; cfg.index = CFG_MODE; cfg.data = 0;
  end

  // Receiver: random stalls, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) result.ready <= 0;
    else result.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    plast_result_t r;
    if (!rst && result.valid && result.ready) begin
      r.syn = result.synapse_out; r.weight = result.weight_out;
      r.fa = result.factor_a_out; r.fb = result.factor_b_out; r.upd = result.updated;
      board.check_result(r);
    end
  end

  task automatic send(logic kind, logic [7:0] s, logic [19:0] w,
                      logic [31:0] cur, logic [31:0] spk, logic fired);
    // step past the falling edge where the previous transfer was dropped
    do @(negedge clk); while ($urandom_range(99) < send_idle);
    request.valid <= 1; request.kind <= kind; request.synapse <= s;
    request.weight_in <= w; request.current_step <= cur;
    request.spike_step <= spk; request.has_fired <= fired;
    do @(posedge clk); while (!request.ready);
    board.note_request(kind, s, w, cur, spk, fired);
    if (kind == 0) loaded[s] = 1;
    @(negedge clk);
    request.valid <= 0;
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] d);
    @(negedge clk);
    cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, d);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Pick a loaded synapse, else load one first.
  task automatic any_loaded(output logic [7:0] s);
    s = 8'($urandom_range(255));
    if (!loaded[s]) begin
      send(0, s, 20'($urandom), 0, 0, 0);
      clock_step[s] = $urandom_range(1000);
    end
  endtask

  task automatic random_item();
    logic [7:0]  s;
    logic [31:0] cur, spk;
    logic [31:0] win;
    int pick;
    pick = $urandom_range(99);
    any_loaded(s);
    win = (board.window == 0) ? 1 : board.window;
    if (pick < 10) begin
      send(0, s, (pick < 2) ? 20'hFFFFF : 20'($urandom), $urandom, $urandom,
           1'($urandom));
    end else if (pick < 80) begin
      // Well-formed spike: advancing step, spike inside the window.
      cur = clock_step[s] + (($urandom_range(3) == 0) ? $urandom_range(70000)
                                                      : $urandom_range(40));
      clock_step[s] = cur;
      spk = cur - $urandom_range(win - 1 > 50 ? 50 : win - 1);
      send(1, s, 20'($urandom), cur, spk, 1);
    end else begin
      send(1, s, 20'($urandom), $urandom, $urandom, 1'($urandom));
    end
  endtask

  task automatic phase(int n);
    for (int i = 0; i < n; i++) random_item();
  endtask

  initial begin
    logic [7:0] s;
    board = new();
    foreach (loaded[i]) loaded[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, each kind, step edges, reset configuration.
    send(0, 0, 0, 0, 0, 0);
    send(0, 255, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send(1, 255, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send(1, 255, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send(1, 255, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send(1, 255, 0, 32'hFFFFFFFE, 32'hFFFFFFFF, 1);
    send(0, 1, 20'h12345, 0, 0, 0);
    send(1, 1, 0, 100, 100, 1);
    send(1, 1, 0, 50, 50, 1);
    send(1, 1, 0, 200, 200, 1);
    send(1, 1, 0, 32'h00100000, 32'h00100000, 1);
    drain();
    write_cfg(CFG_WINDOW, 0);
    send(1, 1, 0, 300, 300, 1);
    drain();
    write_cfg(CFG_MODE, 16'(MODE_OFF));
    write_cfg(CFG_WINDOW, 16'hFFFF);
    send(1, 1, 0, 400, 300, 1);
    drain();
    write_cfg(CFG_MODE, 16'd3);
    send(1, 1, 0, 500, 500, 1);
    drain();
    write_cfg(CFG_MODE, 16'(MODE_DD));
    write_cfg(CFG_DEP1_FAC, 16'h1FFF);
    write_cfg(CFG_DEP2_FAC, 0);
    write_cfg(CFG_DEP1_DEC, 16'h1FFF);
    write_cfg(CFG_DEP2_DEC, 0);
    send(1, 1, 0, 600, 600, 1);
    send(1, 1, 0, 700, 650, 1);
    drain();
    write_cfg(CFG_MODE, 16'(MODE_FD));
    write_cfg(CFG_FAC_INC, 16'hFFFF);
    write_cfg(CFG_FAC_DECAY, 4096);
    write_cfg(CFG_DEP1_DEC, 2048);
    foreach (loaded[i]) clock_step[i] = 1000;
    send(1, 1, 0, 800, 800, 1);
    send(1, 1, 0, 900, 900, 1);

    // Random phases with varying idling and configurations.
    send_idle = 14; recv_idle = 55;
    phase(300);
    drain();
    write_cfg(CFG_FAC_INC, 819); write_cfg(CFG_FAC_DECAY, 4000);
    write_cfg(CFG_DEP1_FAC, 3000); write_cfg(CFG_DEP1_DEC, 4000);
    write_cfg(CFG_WINDOW, 20);
    send_idle = 55; recv_idle = 14;
    phase(300);
    drain();
    write_cfg(CFG_MODE, 16'(MODE_DD)); write_cfg(CFG_DEP2_FAC, 3500);
    write_cfg(CFG_DEP2_DEC, 4095); write_cfg(CFG_WINDOW, 1);
    send_idle = 0; recv_idle = 0;
    phase(300);
    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      phase(40);
    join
    drain();
    write_cfg(CFG_MODE, 16'(MODE_FD));
    for (int k = 0; k < 8; k++)
      write_cfg(cfg_reg_t'(k), 16'((k == 0) ? 32'(MODE_FD) : $urandom_range(4096) + 1));
    recv_idle = 30; send_idle = 30;
    phase(280);
    drain();
    write_cfg(CFG_WINDOW, 16'hFFFF);
    recv_idle = 0; send_idle = 0;
    phase(280);
    drain();

    if (board.errors == 0) $display("[synapse_fac_dep_plasticity] OK");
    else $display("[synapse_fac_dep_plasticity] ERROR");
    $finish;
  end
endmodule
